FILE: hdl/uvs_pkg.sv
// Shared types, widths and constants of the UV-sphere vertex generator.
// No dependencies; every other file takes names from here by scope.
`default_nettype none
package uvs_pkg;

  localparam int CNT_W      = 9;
  localparam int RAD_W      = 10;
  localparam int IDX_W      = 17;
  localparam int TEX_W      = 17;
  localparam int POS_W      = 19;
  localparam int PH_W       = 32;
  localparam int QW         = 33;
  localparam int CW         = 33;
  localparam int TRIG_W     = 32;
  localparam int DIV_STEPS  = 32;
  localparam int TEX_TAP    = 16;
  localparam int LAT_TAP    = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd2;

  localparam logic [CNT_W-1:0] MIN_ROWS    = 9'd2;
  localparam logic [CNT_W-1:0] MIN_COLUMNS = 9'd3;

  localparam logic signed [CW-1:0] GAIN_INV = 33'sd652032874;
  localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PH_W-1:0] EIGHTH_TURN  = 32'h2000_0000;

  localparam logic signed [POS_W-1:0] POS_MAX = 19'sh3FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 19'sh40000;

  typedef struct packed {
    logic [CNT_W-1:0] r;
    logic [QW-1:0]    q;
  } div_lane_t;

  typedef struct packed {
    div_lane_t lon;
    div_lane_t lat;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           quad;
  } cordic_lane_t;

  typedef struct packed {
    cordic_lane_t lat;
    cordic_lane_t lon;
  } cordic_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] clat;
    logic signed [TRIG_W-1:0] slat;
    logic signed [TRIG_W-1:0] clon;
    logic signed [TRIG_W-1:0] slon;
  } trig_t;

  typedef struct packed {
    logic             point_valid;
    logic             upper;
    logic             lower;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic [IDX_W-1:0] k1;
    logic [IDX_W-1:0] k2;
  } side_t;

  // arctangent of 2^-k in binary angle units, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/uvs_div_cell.sv
// One restoring long-division step for the longitude and latitude lanes.
// Depends on uvs_pkg.
`default_nettype none
module uvs_div_cell (
  input  logic                    clk,
  input  logic [uvs_pkg::CNT_W-1:0] lon_div,
  input  logic [uvs_pkg::CNT_W-1:0] lat_div,
  input  uvs_pkg::div_t           div_in,
  output uvs_pkg::div_t           div_out
);

  uvs_pkg::div_t cell_r;
  uvs_pkg::div_t cell_nxt;

  logic [uvs_pkg::CNT_W:0] lon_rr;
  logic [uvs_pkg::CNT_W:0] lat_rr;
  logic                    lon_ge;
  logic                    lat_ge;

  always_comb begin
    lon_rr = {div_in.lon.r, 1'b0};
    lat_rr = {div_in.lat.r, 1'b0};
    lon_ge = lon_rr >= {1'b0, lon_div};
    lat_ge = lat_rr >= {1'b0, lat_div};
    cell_nxt.lon.r = lon_ge ? uvs_pkg::CNT_W'(lon_rr - {1'b0, lon_div})
                            : lon_rr[uvs_pkg::CNT_W-1:0];
    cell_nxt.lat.r = lat_ge ? uvs_pkg::CNT_W'(lat_rr - {1'b0, lat_div})
                            : lat_rr[uvs_pkg::CNT_W-1:0];
    cell_nxt.lon.q = {div_in.lon.q[uvs_pkg::QW-2:0], lon_ge};
    cell_nxt.lat.q = {div_in.lat.q[uvs_pkg::QW-2:0], lat_ge};
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign div_out = cell_r;

endmodule
`default_nettype wire

FILE: hdl/uvs_cordic_cell.sv
// One CORDIC rotation stage applied to both angle lanes.
// Depends on uvs_pkg (arctangent table, lane types).
`default_nettype none
module uvs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  uvs_pkg::cordic_t cord_in,
  output uvs_pkg::cordic_t cord_out
);

  localparam logic signed [uvs_pkg::CW-1:0] ATAN =
    uvs_pkg::CW'(uvs_pkg::atan_turn(STAGE));

  uvs_pkg::cordic_t cell_r;
  uvs_pkg::cordic_t cell_nxt;

  function automatic uvs_pkg::cordic_lane_t rotate(input uvs_pkg::cordic_lane_t a);
    uvs_pkg::cordic_lane_t b;
    b.quad = a.quad;
    if (!a.z[uvs_pkg::CW-1]) begin
      b.x = a.x - (a.y >>> STAGE);
      b.y = a.y + (a.x >>> STAGE);
      b.z = a.z - ATAN;
    end else begin
      b.x = a.x + (a.y >>> STAGE);
      b.y = a.y - (a.x >>> STAGE);
      b.z = a.z + ATAN;
    end
    return b;
  endfunction

  always_comb begin
    cell_nxt.lat = rotate(cord_in.lat);
    cell_nxt.lon = rotate(cord_in.lon);
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cord_out = cell_r;

endmodule
`default_nettype wire

FILE: hdl/uvs_pos_scale.sv
// Position path: trig products, rounding to Q1.30, radius scaling to Q10.8
// with saturation. Three register stages. Depends on uvs_pkg.
`default_nettype none
module uvs_pos_scale (
  input  logic                              clk,
  input  logic [uvs_pkg::RAD_W-1:0]         radius,
  input  uvs_pkg::trig_t                    trig,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]  pos_z
);

  localparam int PW = 64;
  localparam int UW = 34;
  localparam int SW = 45;

  logic signed [PW-1:0]     mx_r, my_r;
  logic signed [uvs_pkg::TRIG_W-1:0] sz_r;
  logic signed [PW-1:0]     mx_rnd, my_rnd;
  logic signed [UW-1:0]     ux, uy;
  logic signed [uvs_pkg::RAD_W:0] rad_s;
  logic signed [SW-1:0]     px_r, py_r, pz_r;
  logic signed [uvs_pkg::POS_W-1:0] x_r, y_r, z_r;

  function automatic logic signed [uvs_pkg::POS_W-1:0] to_pos(input logic signed [SW-1:0] p);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] v;
    logic signed [uvs_pkg::POS_W-1:0] o;
    s = p + SW'(1 << 21);
    v = s >>> 22;
    if (v > SW'(uvs_pkg::POS_MAX)) o = uvs_pkg::POS_MAX;
    else if (v < SW'(uvs_pkg::POS_MIN)) o = uvs_pkg::POS_MIN;
    else o = v[uvs_pkg::POS_W-1:0];
    return o;
  endfunction

  assign mx_rnd = mx_r + PW'(1 << 29);
  assign my_rnd = my_r + PW'(1 << 29);
  assign ux     = mx_rnd[UW+29:30];
  assign uy     = my_rnd[UW+29:30];
  assign rad_s  = signed'({1'b0, radius});

  always_ff @(posedge clk) begin
    mx_r <= trig.clat * trig.clon;
    my_r <= trig.clat * trig.slon;
    sz_r <= trig.slat;
    px_r <= ux * rad_s;
    py_r <= uy * rad_s;
    pz_r <= sz_r * rad_s;
    x_r  <= to_pos(px_r);
    y_r  <= to_pos(py_r);
    z_r  <= to_pos(pz_r);
  end

  assign pos_x = x_r;
  assign pos_y = y_r;
  assign pos_z = z_r;

endmodule
`default_nettype wire

FILE: hdl/uv_sphere_vertex_generator_unit.sv
// UV-sphere vertex generator top level: config registers, division chain,
// CORDIC chain and position scaling. Depends on uvs_pkg and the uvs_ cells.
//
//   channel | handshake          | payload
//   input   | start / busy       | in_row_index, in_column_index
//   result  | out_valid (strobe) | out_point_valid .. out_bottom_left_index
//   config  | cfg_we             | cfg_index, cfg_data
//
// One transaction per clock; busy is always low. Data passes 32 long-division
// cells, CORDIC_STAGES rotation cells, then multipliers. Synchronous active-low
// reset sets the config registers to radius 1, MIN_ROWS and MIN_COLUMNS and
// clears the valid line. The result strobe lasts one cycle; nothing stalls.
`default_nettype none
module uv_sphere_vertex_generator_unit #(
  parameter int MAX_ROWS      = 256,
  parameter int MAX_COLUMNS   = 256,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [uvs_pkg::CNT_W-1:0]            in_row_index,
  input  logic [uvs_pkg::CNT_W-1:0]            in_column_index,
  output logic                                 out_valid,
  output logic                                 out_point_valid,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]     out_pos_z,
  output logic [uvs_pkg::TEX_W-1:0]            out_tex_s,
  output logic [uvs_pkg::TEX_W-1:0]            out_tex_t,
  output logic                                 out_cell_upper_valid,
  output logic                                 out_cell_lower_valid,
  output logic [uvs_pkg::IDX_W-1:0]            out_top_left_index,
  output logic [uvs_pkg::IDX_W-1:0]            out_bottom_left_index,
  input  logic                                 cfg_we,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [uvs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int NDIV = uvs_pkg::DIV_STEPS;
  localparam int SL   = NDIV + CORDIC_STAGES + 5;

  // configuration
  logic [uvs_pkg::RAD_W-1:0] radius_r, radius_nxt;
  logic [uvs_pkg::CNT_W-1:0] rows_r, rows_nxt;
  logic [uvs_pkg::CNT_W-1:0] cols_r, cols_nxt;
  logic [uvs_pkg::CNT_W-1:0] cfg_cnt;

  always_comb begin
    radius_nxt = radius_r;
    rows_nxt   = rows_r;
    cols_nxt   = cols_r;
    cfg_cnt    = cfg_data[uvs_pkg::CNT_W-1:0];
    if (cfg_we) begin
      case (cfg_index)
        uvs_pkg::REG_RADIUS: radius_nxt = cfg_data[uvs_pkg::RAD_W-1:0];
        uvs_pkg::REG_ROWS: begin
          if (cfg_cnt < uvs_pkg::MIN_ROWS) rows_nxt = uvs_pkg::MIN_ROWS;
          else if (32'(cfg_cnt) > MAX_ROWS) rows_nxt = uvs_pkg::CNT_W'(MAX_ROWS);
          else rows_nxt = cfg_cnt;
        end
        uvs_pkg::REG_COLUMNS: begin
          if (cfg_cnt < uvs_pkg::MIN_COLUMNS) cols_nxt = uvs_pkg::MIN_COLUMNS;
          else if (32'(cfg_cnt) > MAX_COLUMNS) cols_nxt = uvs_pkg::CNT_W'(MAX_COLUMNS);
          else cols_nxt = cfg_cnt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= uvs_pkg::RAD_W'(1);
      rows_r   <= uvs_pkg::MIN_ROWS;
      cols_r   <= uvs_pkg::MIN_COLUMNS;
    end else begin
      radius_r <= radius_nxt;
      rows_r   <= rows_nxt;
      cols_r   <= cols_nxt;
    end
  end

  assign busy = 1'b0;

  // entry stage
  logic [uvs_pkg::CNT_W-1:0] ii, jj;
  logic                      ge_i, ge_j, cell_ok;
  uvs_pkg::div_t             div0_nxt, div0_r;
  uvs_pkg::side_t            side0_nxt;
  logic [uvs_pkg::CNT_W+uvs_pkg::CNT_W:0] k1_full;

  always_comb begin
    ii   = in_row_index;
    jj   = in_column_index;
    ge_i = ii >= rows_r;
    ge_j = jj >= cols_r;
    div0_nxt.lat.r = ge_i ? ii - rows_r : ii;
    div0_nxt.lon.r = ge_j ? jj - cols_r : jj;
    div0_nxt.lat.q = {{(uvs_pkg::QW-1){1'b0}}, ge_i};
    div0_nxt.lon.q = {{(uvs_pkg::QW-1){1'b0}}, ge_j};
    cell_ok = (ii < rows_r) && (jj < cols_r);
    k1_full = ii * ({1'b0, cols_r} + 10'd1) + {10'd0, jj};
    side0_nxt.point_valid = (ii <= rows_r) && (jj <= cols_r);
    side0_nxt.upper = cell_ok && (ii != '0);
    side0_nxt.lower = cell_ok && (ii != rows_r - 9'd1);
    side0_nxt.tex_s = '0;
    side0_nxt.tex_t = '0;
    side0_nxt.k1    = k1_full[uvs_pkg::IDX_W-1:0];
    side0_nxt.k2    = uvs_pkg::IDX_W'(k1_full[uvs_pkg::IDX_W-1:0]
                      + {8'd0, cols_r} + 17'd1);
  end

  always_ff @(posedge clk) begin
    div0_r <= div0_nxt;
  end

  // division chain
  uvs_pkg::div_t div_w [0:NDIV];
  assign div_w[0] = div0_r;

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    uvs_div_cell u_div (
      .clk     (clk),
      .lon_div (cols_r),
      .lat_div (rows_r),
      .div_in  (div_w[k-1]),
      .div_out (div_w[k])
    );
  end

  // rounding at the taps
  function automatic logic rnd_up(input logic [uvs_pkg::CNT_W-1:0] r,
                                  input logic [uvs_pkg::CNT_W-1:0] d);
    logic [uvs_pkg::CNT_W:0] s;
    s = {1'b0, r} + {1'b0, d >> 1};
    return s >= {1'b0, d};
  endfunction

  logic [uvs_pkg::TEX_W-1:0] tex_s_c, tex_t_c;
  logic [uvs_pkg::PH_W-1:0]  lat_q_c, lat_ph_c, lon_ph_c;
  logic [uvs_pkg::QW-1:0]    lon_q_c;
  logic [uvs_pkg::PH_W-1:0]  lat_ph_r;

  always_comb begin
    tex_s_c = div_w[uvs_pkg::TEX_TAP].lon.q[uvs_pkg::TEX_W-1:0]
            + uvs_pkg::TEX_W'(rnd_up(div_w[uvs_pkg::TEX_TAP].lon.r, cols_r));
    tex_t_c = div_w[uvs_pkg::TEX_TAP].lat.q[uvs_pkg::TEX_W-1:0]
            + uvs_pkg::TEX_W'(rnd_up(div_w[uvs_pkg::TEX_TAP].lat.r, rows_r));
    lat_q_c = div_w[uvs_pkg::LAT_TAP].lat.q[uvs_pkg::PH_W-1:0]
            + uvs_pkg::PH_W'(rnd_up(div_w[uvs_pkg::LAT_TAP].lat.r, rows_r));
    lat_ph_c = uvs_pkg::QUARTER_TURN - lat_q_c;
    lon_q_c = div_w[NDIV].lon.q
            + uvs_pkg::QW'(rnd_up(div_w[NDIV].lon.r, cols_r));
    lon_ph_c = lon_q_c[uvs_pkg::PH_W-1:0];
  end

  // quadrant reduction
  function automatic uvs_pkg::cordic_lane_t prep(input logic [uvs_pkg::PH_W-1:0] ph);
    uvs_pkg::cordic_lane_t a;
    logic [uvs_pkg::PH_W-1:0] sh;
    logic [uvs_pkg::PH_W-1:0] rem;
    sh     = ph + uvs_pkg::EIGHTH_TURN;
    a.quad = sh[uvs_pkg::PH_W-1 -: 2];
    rem    = ph - {a.quad, 30'd0};
    a.z    = signed'({rem[uvs_pkg::PH_W-1], rem});
    a.x    = uvs_pkg::GAIN_INV;
    a.y    = '0;
    return a;
  endfunction

  uvs_pkg::cordic_t prep_r;

  always_ff @(posedge clk) begin
    lat_ph_r   <= lat_ph_c;
    prep_r.lat <= prep(lat_ph_r);
    prep_r.lon <= prep(lon_ph_c);
  end

  // CORDIC chain
  uvs_pkg::cordic_t cord_w [0:CORDIC_STAGES];
  assign cord_w[0] = prep_r;

  for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cord
    uvs_cordic_cell #(.STAGE(k - 1)) u_cord (
      .clk      (clk),
      .cord_in  (cord_w[k-1]),
      .cord_out (cord_w[k])
    );
  end

  // quadrant restore
  function automatic logic signed [uvs_pkg::TRIG_W-1:0] cos_of(input uvs_pkg::cordic_lane_t a);
    logic signed [uvs_pkg::CW-1:0] v;
    case (a.quad)
      2'd0:    v = a.x;
      2'd1:    v = -a.y;
      2'd2:    v = -a.x;
      default: v = a.y;
    endcase
    return v[uvs_pkg::TRIG_W-1:0];
  endfunction

  function automatic logic signed [uvs_pkg::TRIG_W-1:0] sin_of(input uvs_pkg::cordic_lane_t a);
    logic signed [uvs_pkg::CW-1:0] v;
    case (a.quad)
      2'd0:    v = a.y;
      2'd1:    v = a.x;
      2'd2:    v = -a.y;
      default: v = -a.x;
    endcase
    return v[uvs_pkg::TRIG_W-1:0];
  endfunction

  uvs_pkg::trig_t trig_r;

  always_ff @(posedge clk) begin
    trig_r.clat <= cos_of(cord_w[CORDIC_STAGES].lat);
    trig_r.slat <= sin_of(cord_w[CORDIC_STAGES].lat);
    trig_r.clon <= cos_of(cord_w[CORDIC_STAGES].lon);
    trig_r.slon <= sin_of(cord_w[CORDIC_STAGES].lon);
  end

  logic signed [uvs_pkg::POS_W-1:0] px, py, pz;

  uvs_pos_scale u_pos (
    .clk    (clk),
    .radius (radius_r),
    .trig   (trig_r),
    .pos_x  (px),
    .pos_y  (py),
    .pos_z  (pz)
  );

  // side data and transaction valid line
  uvs_pkg::side_t sd_r  [0:SL];
  logic           vld_r [0:SL];
  uvs_pkg::side_t sd_tex_c;

  always_comb begin
    sd_tex_c       = sd_r[uvs_pkg::TEX_TAP];
    sd_tex_c.tex_s = tex_s_c;
    sd_tex_c.tex_t = tex_t_c;
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= side0_nxt;
    for (int k = 1; k <= SL; k++) begin
      if (k == uvs_pkg::TEX_TAP + 1) sd_r[k] <= sd_tex_c;
      else sd_r[k] <= sd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SL; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k <= SL; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  logic pv;
  assign pv = sd_r[SL].point_valid;

  assign out_valid             = vld_r[SL];
  assign out_point_valid       = pv;
  assign out_pos_x             = pv ? px : '0;
  assign out_pos_y             = pv ? py : '0;
  assign out_pos_z             = pv ? pz : '0;
  assign out_tex_s             = pv ? sd_r[SL].tex_s : '0;
  assign out_tex_t             = pv ? sd_r[SL].tex_t : '0;
  assign out_cell_upper_valid  = pv && sd_r[SL].upper;
  assign out_cell_lower_valid  = pv && sd_r[SL].lower;
  assign out_top_left_index    = pv ? sd_r[SL].k1 : '0;
  assign out_bottom_left_index = pv ? sd_r[SL].k2 : '0;

endmodule
`default_nettype wire

FILE: hdl/uvs_checker.sv
// Port-level checks for the UV-sphere vertex generator, bound to the top.
// Depends on uvs_pkg and uv_sphere_vertex_generator_unit.
`default_nettype none
module uvs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_point_valid,
  input logic                          out_cell_upper_valid,
  input logic                          out_cell_lower_valid,
  input logic [uvs_pkg::TEX_W-1:0]     out_tex_s,
  input logic [uvs_pkg::IDX_W-1:0]     out_top_left_index
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_cells_need_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cell_upper_valid || out_cell_lower_valid) |-> out_point_valid)
    else $error("cell flag on invalid point");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_tex_s == '0 && out_top_left_index == '0)
    else $error("invalid point carries data");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_s <= 17'd65536)
    else $error("texture coordinate above 1.0");

endmodule

bind uv_sphere_vertex_generator_unit uvs_checker u_uvs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_point_valid      (out_point_valid),
  .out_cell_upper_valid (out_cell_upper_valid),
  .out_cell_lower_valid (out_cell_lower_valid),
  .out_tex_s            (out_tex_s),
  .out_top_left_index   (out_top_left_index)
);
`default_nettype wire

FILE: tb/tb_uv_sphere_vertex_generator_unit.sv
// Self-checking testbench for uv_sphere_vertex_generator_unit: drives grid points,
// predicts position, texture and cell indices per point and compares each result.
// Depends on uvs_pkg and the unit's RTL.
`timescale 1ns / 100ps
module tb_uv_sphere_vertex_generator_unit;

  localparam logic [uvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LATENCY = 16 + 38;
  localparam longint ARCTAN_TURN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  typedef struct {
    logic [uvs_pkg::CNT_W-1:0] row;
    logic [uvs_pkg::CNT_W-1:0] col;
  } grid_point_t;

  typedef struct {
    longint point_valid, pos_x, pos_y, pos_z, tex_s, tex_t;
    longint upper, lower, k1, k2;
  } vertex_t;

  logic clk = 0, rst_n = 0, start = 0, cfg_we = 0;
  logic busy, out_valid, out_point_valid, out_cell_upper_valid, out_cell_lower_valid;
  logic [uvs_pkg::CNT_W-1:0] in_row_index = '0, in_column_index = '0;
  logic signed [uvs_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [uvs_pkg::TEX_W-1:0] out_tex_s, out_tex_t;
  logic [uvs_pkg::IDX_W-1:0] out_top_left_index, out_bottom_left_index;
  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_point_t pending_points[$];
  vertex_t expected_vertices[$];
  longint radius = 1, rows = 2, cols = 3;
  int idle_pct = 0;
  int errors = 0;

  uv_sphere_vertex_generator_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic void rotate(input longint phase, output longint c, output longint s);
    longint q, z, x, y, nx;
    q = (((phase + 64'h2000_0000) & 64'hFFFF_FFFF) >> 30) & 3;
    z = (phase - q * 64'h4000_0000) & 64'hFFFF_FFFF;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        y = y + (x >>> k);
        z -= ARCTAN_TURN[k];
      end else begin
        nx = x + (y >>> k);
        y = y - (x >>> k);
        z += ARCTAN_TURN[k];
      end
      x = nx;
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint scale_pos(input longint unit_q30);
    longint v;
    v = (unit_q30 * radius + (64'sd1 <<< 21)) >>> 22;
    if (v < -262144) v = -262144;
    if (v > 262143) v = 262143;
    return v;
  endfunction

  function automatic vertex_t predict_vertex(input grid_point_t p);
    vertex_t v;
    longint i, j, lon, lat, clat, slat, clon, slon;
    bit cell_ok;
    v = '{default: 0};
    i = p.row;
    j = p.col;
    if (i > rows || j > cols) return v;
    lon = (((j << 32) + cols / 2) / cols) & 64'hFFFF_FFFF;
    lat = (64'h4000_0000 - ((i << 31) + rows / 2) / rows) & 64'hFFFF_FFFF;
    rotate(lat, clat, slat);
    rotate(lon, clon, slon);
    v.point_valid = 1;
    v.pos_x = scale_pos((clat * clon + (64'sd1 <<< 29)) >>> 30);
    v.pos_y = scale_pos((clat * slon + (64'sd1 <<< 29)) >>> 30);
    v.pos_z = scale_pos(slat);
    v.tex_s = (((j << 16) + cols / 2) / cols) & 64'h1FFFF;
    v.tex_t = (((i << 16) + rows / 2) / rows) & 64'h1FFFF;
    cell_ok = (i < rows) && (j < cols);
    v.upper = cell_ok && i != 0;
    v.lower = cell_ok && i != rows - 1;
    v.k1 = (i * (cols + 1) + j) & 64'h1FFFF;
    v.k2 = (i * (cols + 1) + j + cols + 1) & 64'h1FFFF;
    return v;
  endfunction

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
      grid_point_t p;
      p = pending_points.pop_front();
      start <= 1;
      in_row_index <= p.row;
      in_column_index <= p.col;
    end else begin
      start <= 0;
      in_row_index <= uvs_pkg::CNT_W'($urandom);
      in_column_index <= uvs_pkg::CNT_W'($urandom);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_vertices.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        vertex_t e;
        e = expected_vertices.pop_front();
        check_field("point_valid", e.point_valid, out_point_valid);
        check_field("pos_x", e.pos_x, $signed(out_pos_x));
        check_field("pos_y", e.pos_y, $signed(out_pos_y));
        check_field("pos_z", e.pos_z, $signed(out_pos_z));
        check_field("tex_s", e.tex_s, out_tex_s);
        check_field("tex_t", e.tex_t, out_tex_t);
        check_field("cell_upper_valid", e.upper, out_cell_upper_valid);
        check_field("cell_lower_valid", e.lower, out_cell_lower_valid);
        check_field("top_left_index", e.k1, out_top_left_index);
        check_field("bottom_left_index", e.k2, out_bottom_left_index);
      end
    end
    if (rst_n && start && !busy)
      expected_vertices.insert(expected_vertices.size(),
                               predict_vertex('{in_row_index, in_column_index}));
  end

  task automatic write_reg(input logic [uvs_pkg::CFG_IDX_W-1:0] idx, input longint val);
    longint v;
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= uvs_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    v = val & 10'h1FF;
    case (idx)
      uvs_pkg::REG_RADIUS: radius = val & 10'h3FF;
      uvs_pkg::REG_ROWS: rows = v < 2 ? 2 : (v > 256 ? 256 : v);
      uvs_pkg::REG_COLUMNS: cols = v < 3 ? 3 : (v > 256 ? 256 : v);
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_points.size() > 0 || expected_vertices.size() > 0 || start);
  endtask

  task automatic add_point(input longint r, input longint c);
    pending_points.insert(pending_points.size(),
                          '{uvs_pkg::CNT_W'(r), uvs_pkg::CNT_W'(c)});
  endtask

  initial begin
    longint rad_set [8] = '{1023, 0, 1, 700, 37, 1023, 5, 255};
    longint row_set [8] = '{256, 0, 1, 300, 7, 511, 129, 3};
    longint col_set [8] = '{256, 0, 2, 1023, 11, 4, 200, 255};
    int idle_set [8] = '{0, 68, 25, 0, 68, 25, 0, 68};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    write_reg(REG_UNUSED, 1023);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(uvs_pkg::REG_RADIUS, rad_set[ph]);
      write_reg(uvs_pkg::REG_ROWS, row_set[ph]);
      write_reg(uvs_pkg::REG_COLUMNS, col_set[ph]);
      idle_pct = idle_set[ph];
      if (ph == 0) begin
        add_point(0, 0);
        add_point(rows, cols);
        add_point(rows - 1, cols - 1);
        add_point(rows, 0);
        add_point(0, cols);
        add_point(1, 1);
        add_point(rows + 1, 0);
        add_point(0, cols + 1);
        add_point(511, 511);
        add_point(rows / 2, cols / 4);
        add_point(rows / 2, cols / 2);
        add_point(rows / 4, 3 * cols / 4);
        add_point(rows - 1, 0);
        add_point(256, 256);
        add_point(257, 255);
      end
      for (int n = 0; n < 160; n++) begin
        if ($urandom_range(99) < 15)
          add_point($urandom_range(511), $urandom_range(511));
        else
          add_point($urandom_range(rows), $urandom_range(cols));
      end
      if (ph == 3) begin
        drain();
        for (int n = 0; n < 20; n++) add_point($urandom_range(rows), $urandom_range(cols));
      end
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_vertices.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/uvs_pkg.sv
hdl/uvs_div_cell.sv
hdl/uvs_cordic_cell.sv
hdl/uvs_pos_scale.sv
hdl/uv_sphere_vertex_generator_unit.sv
hdl/uvs_checker.sv
tb/tb_uv_sphere_vertex_generator_unit.sv
